>>> hdl/msplit_pkg.sv
// Package: shared constants, types and register indexes for the delimiter splitter.
`timescale 1ns / 1ps
package msplit_pkg;
	localparam int MAX_DELIM = 8;
	localparam int LEN_W     = 4;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 64;

	localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 1'b1;

	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              is_byte;
		logic              final_piece;
		logic              run_last;
	} result_t;
endpackage

>>> hdl/multibyte_delimiter_splitter.sv
// Top level: splits a byte string into pieces at a configured multibyte delimiter.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, in_byte, has_byte,         | sink
//          | string_last                                    |
//  out     | out_valid, out_stall, out_byte, is_byte,       | source
//          | final_piece, run_last                          |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | sink
//
// A byte word with a nonzero delimiter length gives at most one result as it is taken,
// unless it ends the string. At most one result leaves the engine per cycle, while the queue has space.
// The final flush of a string gives one result per pending byte plus one for the piece end.
// Length zero gives two results per byte (byte, then piece end). After a delimiter hit
// with more bytes pending than its length, S_SKIP shifts the delimiter out of the window.
// Reset clears the control state and the registers; window bytes need no reset.
// The two-entry output queue lets the engine run on while a result is stalled.
`timescale 1ns / 1ps
module multibyte_delimiter_splitter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [msplit_pkg::BYTE_W-1:0]        in_byte,
	input  logic                                 has_byte,
	input  logic                                 string_last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [msplit_pkg::BYTE_W-1:0]        out_byte,
	output logic                                 is_byte,
	output logic                                 final_piece,
	output logic                                 run_last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [msplit_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msplit_pkg::CFG_W-1:0]         cfg_data
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOP  = 3'd1;
	localparam logic [2:0] S_SKIP  = 3'd2;
	localparam logic [2:0] S_FLUSH = 3'd3;
	localparam logic [2:0] S_END   = 3'd4;

	localparam int LW = msplit_pkg::LEN_W;
	localparam int BW = msplit_pkg::BYTE_W;
	localparam int MD = msplit_pkg::MAX_DELIM;

	logic [LW-1:0]             len_q;
	logic [msplit_pkg::CFG_W-1:0] delim_q;
	logic [LW-1:0]             len_c;
	logic [2:0]                state_q, state_d;
	logic [LW-1:0]             fill_q, fill_d;
	logic [LW-1:0]             cnt_q, cnt_d;
	logic                      last_q, last_d;
	logic                      acc;
	logic                      space;
	logic                      push;
	logic                      ins_en;
	logic                      shift_en;
	msplit_pkg::result_t       res;
	msplit_pkg::result_t       head;
	logic [BW-1:0]             eff_w [MD+1];
	logic [MD-1:0]             hit_w;
	logic [MD-1:0]             len_mask;
	logic                      match_c;
	logic [LW-1:0]             f_inc;
	logic [LW-1:0]             f_dec;
	logic [LW-1:0]             f_rem;

	assign cfg_ready = 1'b1;
	assign len_c     = (len_q > LW'(MD)) ? LW'(MD) : len_q;
	assign in_stall  = (state_q != S_IDLE) | ~space;
	assign acc       = in_valid & ~in_stall;
	assign eff_w[MD] = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			delim_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				msplit_pkg::REG_DELIM_LEN:   len_q   <= cfg_data[LW-1:0];
				msplit_pkg::REG_DELIM_BYTES: delim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < MD; i++) begin : g_cell
		msplit_pkg::cell_ctl_t ctl;
		assign ctl.ins     = ins_en && (fill_q == LW'(i));
		assign ctl.shift   = shift_en;
		assign len_mask[i] = (LW'(i) < len_c);
		msplit_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.in_byte (in_byte),
			.nbr     (eff_w[i+1]),
			.delim   (delim_q[BW*i +: BW]),
			.eff     (eff_w[i]),
			.hit     (hit_w[i])
		);
	end

	assign match_c = &(hit_w | ~len_mask);
	assign f_inc   = fill_q + LW'(1);
	assign f_dec   = fill_q - LW'(1);
	assign f_rem   = fill_q - len_c;

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		cnt_d    = cnt_q;
		last_d   = last_q;
		push     = 1'b0;
		ins_en   = 1'b0;
		shift_en = 1'b0;
		res      = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					last_d = string_last;
					if (len_c == '0) begin
						if (has_byte) begin
							if (fill_q == '0) begin
								push         = 1'b1;
								res.out_byte = in_byte;
								res.is_byte  = 1'b1;
								state_d      = S_END;
							end else begin
								ins_en  = 1'b1;
								fill_d  = f_inc;
								state_d = S_FLUSH;
							end
						end else if (string_last && fill_q != '0) begin
							state_d = S_FLUSH;
						end
					end else if (has_byte) begin
						ins_en = (fill_q < LW'(MD));
						if (f_inc == len_c) begin
							push         = 1'b1;
							res.run_last = ~string_last;
							if (match_c) begin
								fill_d  = '0;
								state_d = string_last ? S_END : S_IDLE;
							end else begin
								res.out_byte = eff_w[0];
								res.is_byte  = 1'b1;
								shift_en     = 1'b1;
								fill_d       = len_c - LW'(1);
								if (!string_last) begin
									state_d = S_IDLE;
								end else begin
									state_d = (len_c != LW'(1)) ? S_FLUSH : S_END;
								end
							end
						end else if (f_inc > len_c) begin
							fill_d  = f_inc;
							state_d = S_LOOP;
						end else begin
							fill_d  = f_inc;
							state_d = string_last ? S_FLUSH : S_IDLE;
						end
					end else if (string_last) begin
						if (fill_q >= len_c) begin
							state_d = S_LOOP;
						end else begin
							state_d = (fill_q != '0) ? S_FLUSH : S_END;
						end
					end
				end
			end
			S_LOOP: begin
				if (space) begin
					push = 1'b1;
					if (match_c) begin
						if (fill_q == len_c) begin
							fill_d       = '0;
							res.run_last = ~last_q;
							state_d      = last_q ? S_END : S_IDLE;
						end else begin
							cnt_d        = len_c;
							res.run_last = ~(last_q | (f_rem >= len_c));
							state_d      = S_SKIP;
						end
					end else begin
						res.out_byte = eff_w[0];
						res.is_byte  = 1'b1;
						res.run_last = ~(last_q | (f_dec >= len_c));
						shift_en     = 1'b1;
						fill_d       = f_dec;
						if (f_dec >= len_c) begin
							state_d = S_LOOP;
						end else if (last_q) begin
							state_d = (f_dec != '0) ? S_FLUSH : S_END;
						end else begin
							state_d = S_IDLE;
						end
					end
				end
			end
			S_SKIP: begin
				shift_en = 1'b1;
				fill_d   = f_dec;
				cnt_d    = cnt_q - LW'(1);
				if (cnt_q == LW'(1)) begin
					if (f_dec >= len_c) begin
						state_d = S_LOOP;
					end else if (last_q) begin
						state_d = (f_dec != '0) ? S_FLUSH : S_END;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_FLUSH: begin
				if (space) begin
					push         = 1'b1;
					res.out_byte = eff_w[0];
					res.is_byte  = 1'b1;
					shift_en     = 1'b1;
					fill_d       = f_dec;
					if (fill_q == LW'(1)) begin
						state_d = S_END;
					end
				end
			end
			S_END: begin
				if (space) begin
					push            = 1'b1;
					res.final_piece = last_q;
					res.run_last    = 1'b1;
					last_d          = 1'b0;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			cnt_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			cnt_q   <= cnt_d;
			last_q  <= last_d;
		end
	end

	msplit_ofifo u_ofifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (res),
		.space  (space),
		.valid  (out_valid),
		.stall  (out_stall),
		.dout   (head)
	);

	assign out_byte    = head.out_byte;
	assign is_byte     = head.is_byte;
	assign final_piece = head.final_piece;
	assign run_last    = head.run_last;
endmodule

>>> hdl/msplit_cell.sv
// Window cell: holds one lookahead byte, compares it with its delimiter byte.
`timescale 1ns / 1ps
module msplit_cell (
	input  logic                           clk,
	input  msplit_pkg::cell_ctl_t          ctl,
	input  logic [msplit_pkg::BYTE_W-1:0]  in_byte,
	input  logic [msplit_pkg::BYTE_W-1:0]  nbr,
	input  logic [msplit_pkg::BYTE_W-1:0]  delim,
	output logic [msplit_pkg::BYTE_W-1:0]  eff,
	output logic                           hit
);
	logic [msplit_pkg::BYTE_W-1:0] byte_q;

	assign eff = ctl.ins ? in_byte : byte_q;
	assign hit = (eff == delim);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= nbr;
		end else if (ctl.ins) begin
			byte_q <= in_byte;
		end
	end
endmodule

>>> hdl/msplit_ofifo.sv
// Output skid queue: two result entries between the engine and the output port.
`timescale 1ns / 1ps
module msplit_ofifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  msplit_pkg::result_t din,
	output logic                space,
	output logic                valid,
	input  logic                stall,
	output msplit_pkg::result_t dout
);
	msplit_pkg::result_t ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign valid = (cnt_q != 2'd0);
	assign space = (cnt_q != 2'd2);
	assign pop   = valid & ~stall;
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

>>> sim/multibyte_delimiter_splitter_test.sv
// Self-checking testbench for the multibyte delimiter splitter: directed table, random strings.
`timescale 1ns / 1ps
module multibyte_delimiter_splitter_test;
	localparam int RAND_WORDS    = 350;
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_CYCLES  = 40;
	localparam int LIMIT_CYCLES  = 500000;
	localparam int MAX_MSGS      = 100;
	localparam int NUM_DIR       = 33;

	typedef enum logic [0:0] {ROW_WORD, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_RAND, STALL_EVERY_THIRD, STALL_BLOCK} stall_mode_t;

	typedef struct packed {
		row_kind_t                             kind;
		logic [msplit_pkg::CFG_IDX_W-1:0]      idx;
		logic [msplit_pkg::CFG_W-1:0]          data;
		logic [msplit_pkg::BYTE_W-1:0]         b;
		logic                                  hb;
		logic                                  last;
		int                                    n_typed;
		msplit_pkg::result_t                   r0;
		msplit_pkg::result_t                   r1;
	} dir_row_t;

	localparam msplit_pkg::result_t R_NIL = '0;
	localparam msplit_pkg::result_t R_B00 = '{8'h00, 1'b1, 1'b0, 1'b0};
	localparam msplit_pkg::result_t R_BFF = '{8'hFF, 1'b1, 1'b0, 1'b0};
	localparam msplit_pkg::result_t R_END = '{8'h00, 1'b0, 1'b0, 1'b1};
	localparam msplit_pkg::result_t R_FIN = '{8'h00, 1'b0, 1'b1, 1'b1};

	localparam dir_row_t DIR_TAB [NUM_DIR] = '{
		'{ROW_WORD, '0, '0, 8'h00, 1'b1, 1'b0, 2, R_B00, R_END},
		'{ROW_WORD, '0, '0, 8'hFF, 1'b1, 1'b1, 2, R_BFF, R_FIN},
		'{ROW_WORD, '0, '0, 8'h5A, 1'b0, 1'b0, 0, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'hA5, 1'b0, 1'b1, 0, R_NIL, R_NIL},
		'{ROW_CFG, msplit_pkg::REG_DELIM_LEN, 64'd2, 8'h00, 1'b0, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_CFG, msplit_pkg::REG_DELIM_BYTES, 64'h3B2C, 8'h00, 1'b0, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h00, 1'b0, 1'b1, 1, R_FIN, R_NIL},
		'{ROW_WORD, '0, '0, 8'h2C, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h3B, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h78, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h2C, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h2C, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h3B, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h7A, 1'b1, 1'b1, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h2C, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_CFG, msplit_pkg::REG_DELIM_LEN, 64'd0, 8'h00, 1'b0, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h00, 1'b0, 1'b1, -1, R_NIL, R_NIL},
		'{ROW_CFG, msplit_pkg::REG_DELIM_LEN, 64'd15, 8'h00, 1'b0, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_CFG, msplit_pkg::REG_DELIM_BYTES, '1, 8'h00, 1'b0, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'hFF, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'hFF, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'hFF, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'hFF, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'hFF, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'hFF, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'hFF, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'hFF, 1'b1, 1'b1, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h00, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h00, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h00, 1'b1, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_CFG, msplit_pkg::REG_DELIM_BYTES, 64'd0, 8'h00, 1'b0, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_CFG, msplit_pkg::REG_DELIM_LEN, 64'd1, 8'h00, 1'b0, 1'b0, -1, R_NIL, R_NIL},
		'{ROW_WORD, '0, '0, 8'h00, 1'b0, 1'b1, -1, R_NIL, R_NIL}
	};

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  in_valid = 1'b0;
	logic                                  in_stall;
	logic [msplit_pkg::BYTE_W-1:0]         in_byte = '0;
	logic                                  has_byte = 1'b0;
	logic                                  string_last = 1'b0;
	logic                                  out_valid;
	logic                                  out_stall = 1'b0;
	logic [msplit_pkg::BYTE_W-1:0]         out_byte;
	logic                                  is_byte;
	logic                                  final_piece;
	logic                                  run_last;
	logic                                  cfg_valid = 1'b0;
	logic                                  cfg_ready;
	logic [msplit_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [msplit_pkg::CFG_W-1:0]          cfg_data = '0;

	logic [msplit_pkg::BYTE_W-1:0]         win [msplit_pkg::MAX_DELIM] = '{default: '0};
	int unsigned                           win_fill = 0;
	logic [msplit_pkg::LEN_W-1:0]          split_len = '0;
	logic [msplit_pkg::CFG_W-1:0]          split_delim = '0;
	msplit_pkg::result_t                   step_q [$];
	msplit_pkg::result_t                   piece_exp_q [$];
	msplit_pkg::result_t                   want;
	logic [msplit_pkg::BYTE_W-1:0]         alpha [3] = '{8'h2C, 8'h61, 8'h00};

	int                     fails = 0;
	int unsigned            cycles = 0;
	int unsigned            burst_left = 0;
	int unsigned            stall_left = 0;
	stall_mode_t            stall_mode = STALL_NONE;

	multibyte_delimiter_splitter i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.has_byte    (has_byte),
		.string_last (string_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.is_byte     (is_byte),
		.final_piece (final_piece),
		.run_last    (run_last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("%0t ns: timeout, %0d results still expected", $time, piece_exp_q.size());
			$display("** multibyte_delimiter_splitter: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(8, 64);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:        out_stall <= 1'b0;
			STALL_RAND:        out_stall <= ($urandom_range(0, 2) == 0);
			STALL_EVERY_THIRD: out_stall <= (cycles % 3 == 0);
			default:           out_stall <= stall_left[2];
		endcase
	end

	function automatic int unsigned delim_span();
		return (split_len > msplit_pkg::MAX_DELIM) ? msplit_pkg::MAX_DELIM : split_len;
	endfunction

	function automatic void add_piece_result(logic [msplit_pkg::BYTE_W-1:0] b, logic isb,
			logic fin);
		msplit_pkg::result_t r;
		r = '{b, isb, fin, 1'b0};
		step_q = {step_q, r};
	endfunction

	function automatic void drop_front(int unsigned k);
		if (k >= win_fill) begin
			win_fill = 0;
		end else begin
			for (int unsigned i = 0; i + k < win_fill; i++)
				win[i] = win[i + k];
			win_fill -= k;
		end
	endfunction

	function automatic void flush_window();
		for (int unsigned i = 0; i < win_fill; i++)
			add_piece_result(win[i], 1'b1, 1'b0);
		win_fill = 0;
	endfunction

	// Pieces caused by one word, into step_q.
	function automatic void split_word(logic [msplit_pkg::BYTE_W-1:0] b, logic hb, logic last);
		int unsigned n;
		logic hit;
		n = delim_span();
		step_q.delete();
		if (n == 0) begin
			if (hb || (last && win_fill > 0)) begin
				flush_window();
				if (hb)
					add_piece_result(b, 1'b1, 1'b0);
				add_piece_result('0, 1'b0, last);
			end
			if (last)
				win_fill = 0;
		end else begin
			if (hb && win_fill < msplit_pkg::MAX_DELIM) begin
				win[win_fill] = b;
				win_fill++;
			end
			if (hb || last) begin
				while (win_fill >= n) begin
					hit = 1'b1;
					for (int unsigned i = 0; i < n; i++)
						if (win[i] != split_delim[8 * i +: 8])
							hit = 1'b0;
					if (hit) begin
						add_piece_result('0, 1'b0, 1'b0);
						drop_front(n);
					end else begin
						add_piece_result(win[0], 1'b1, 1'b0);
						drop_front(1);
					end
				end
			end
			if (last) begin
				flush_window();
				add_piece_result('0, 1'b0, 1'b1);
			end
		end
		if (step_q.size() > 0)
			step_q[step_q.size() - 1].run_last = 1'b1;
	endfunction

	function automatic void note_field(string name, logic [msplit_pkg::BYTE_W-1:0] exp_v,
			logic [msplit_pkg::BYTE_W-1:0] act_v);
		if (exp_v !== act_v) begin
			fails++;
			if (fails <= MAX_MSGS)
				$display("%0t ns: %s expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (piece_exp_q.size() == 0) begin
				fails++;
				if (fails <= MAX_MSGS)
					$display("%0t ns: result expected none, got byte %0h is_byte %0b final %0b",
						$time, out_byte, is_byte, final_piece);
			end else begin
				want = piece_exp_q.pop_front();
				note_field("out_byte", want.out_byte, out_byte);
				note_field("is_byte", want.is_byte, is_byte);
				note_field("final_piece", want.final_piece, final_piece);
				note_field("run_last", want.run_last, run_last);
			end
		end
	end

	task automatic drive_word(input logic [msplit_pkg::BYTE_W-1:0] b, input logic hb,
			input logic last, input int n_typed = -1,
			input msplit_pkg::result_t r0 = '0, input msplit_pkg::result_t r1 = '0);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		split_word(b, hb, last);
		if (n_typed < 0) begin
			foreach (step_q[i])
				piece_exp_q = {piece_exp_q, step_q[i]};
		end else begin
			if (n_typed > 0)
				piece_exp_q = {piece_exp_q, r0};
			if (n_typed > 1)
				piece_exp_q = {piece_exp_q, r1};
		end
		in_valid <= 1'b1;
		in_byte <= b;
		has_byte <= hb;
		string_last <= last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [msplit_pkg::CFG_IDX_W-1:0] idx,
			input logic [msplit_pkg::CFG_W-1:0] data);
		in_valid <= 1'b0;
		while (piece_exp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == msplit_pkg::REG_DELIM_LEN)
			split_len = data[msplit_pkg::LEN_W-1:0];
		else
			split_delim = data;
	endtask

	task automatic retune(input bit whole);
		logic [msplit_pkg::CFG_W-1:0] d;
		int unsigned r;
		bit do_len;
		do_len = whole || $urandom_range(0, 1);
		if (whole)
			for (int k = 0; k < 3; k++)
				alpha[k] = 8'($urandom);
		if (do_len) begin
			r = $urandom_range(0, 19);
			d = {$urandom, $urandom};
			if ($urandom_range(0, 3) != 0)
				d[msplit_pkg::CFG_W-1:msplit_pkg::LEN_W] = '0;
			d[msplit_pkg::LEN_W-1:0] = (r < 2) ? 4'd0 : (r < 4) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(1, 8));
			write_reg(msplit_pkg::REG_DELIM_LEN, d);
		end
		if (whole || !do_len) begin
			r = $urandom_range(0, 19);
			if (r < 3) begin
				d = (r == 0) ? '0 : '1;
			end else if (r < 10) begin
				d = {$urandom, $urandom};
			end else begin
				for (int k = 0; k < msplit_pkg::MAX_DELIM; k++)
					d[8 * k +: 8] = alpha[$urandom_range(0, 2)];
			end
			write_reg(msplit_pkg::REG_DELIM_BYTES, d);
		end
	endtask

	function automatic logic [msplit_pkg::BYTE_W-1:0] text_byte();
		int unsigned span;
		int unsigned pos;
		span = delim_span();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'($urandom);
			4, 5, 6:    return alpha[$urandom_range(0, 2)];
			default: begin
				if (span == 0)
					return alpha[0];
				pos = $urandom_range(0, span - 1);
				return split_delim[8 * pos +: 8];
			end
		endcase
	endfunction

	initial begin
		int unsigned words;
		int unsigned body_len;
		int unsigned span;
		int unsigned k;
		bit noisy;
		bit tail_byte;
		logic [msplit_pkg::BYTE_W-1:0] str_q [$];

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TAB[r]) begin
			if (DIR_TAB[r].kind == ROW_CFG)
				write_reg(DIR_TAB[r].idx, DIR_TAB[r].data);
			else
				drive_word(DIR_TAB[r].b, DIR_TAB[r].hb, DIR_TAB[r].last,
					DIR_TAB[r].n_typed, DIR_TAB[r].r0, DIR_TAB[r].r1);
		end

		words = 0;
		while (words < RAND_WORDS) begin
			if (words == 0 || $urandom_range(0, 2) == 0)
				retune(1'b1);
			span = delim_span();
			str_q.delete();
			body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 10);
			noisy = ($urandom_range(0, 9) == 0);
			while (str_q.size() < body_len) begin
				if (!noisy && span > 0 && $urandom_range(0, 3) == 0) begin
					// whole delimiter, or a broken prefix of it
					k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span) : span;
					for (int unsigned i = 0; i < k; i++)
						str_q = {str_q, split_delim[8 * i +: 8]};
				end else begin
					str_q = {str_q, noisy ? 8'($urandom) : text_byte()};
				end
			end
			tail_byte = (str_q.size() != 0) && $urandom_range(0, 1);
			for (int i = 0; i < str_q.size(); i++) begin
				if ($urandom_range(0, 9) == 0) begin
					drive_word(8'($urandom), 1'b0, 1'b0);
					words++;
				end
				if ($urandom_range(0, 24) == 0)
					retune(1'b0);
				drive_word(str_q[i], 1'b1, tail_byte && i == str_q.size() - 1);
				words++;
			end
			if (!tail_byte) begin
				drive_word(8'($urandom), 1'b0, 1'b1);
				words++;
			end
		end

		in_valid <= 1'b0;
		while (piece_exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("** multibyte_delimiter_splitter: PASSED **");
		else
			$display("** multibyte_delimiter_splitter: FAILED **");
		$finish;
	end
endmodule
